[design/sorted_list_insert_remove_core_assert.svh]
// Assertion macros shared by the sorted list core.
`ifndef SORTED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sorted list check failed");

// Next-cycle implication, checked outside reset.
`define SLI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sorted list check failed");

`endif

[design/sli_pkg.sv]
// Types and constants of the sorted list core.
`default_nettype none

package sli_pkg;

    localparam int SLI_CAPACITY = 256;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_APPEND = 2'd2,
        OP_DROP   = 2'd3
    } sli_op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DROP_BIG  = 2'd3
    } sli_status_t;

    typedef struct packed {
        sli_op_t     op;
        logic [7:0]  element_id;
        logic [7:0]  sort_key;
        logic [8:0]  drop_count;
    } sli_req_t;

    typedef struct packed {
        sli_status_t status;
        logic [8:0]  list_size;
        logic        head_valid;
        logic [7:0]  head_element;
        logic [7:0]  head_key;
    } sli_rsp_t;

    typedef struct packed {
        logic [7:0] element;
        logic [7:0] key;
    } sli_entry_t;

    // What one cell loads in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT
    } sli_cell_act_t;

    // Command to the whole row of cells.
    typedef enum logic [2:0] {
        CHAIN_HOLD,
        CHAIN_SCAN,
        CHAIN_PLACE,
        CHAIN_CLOSE,
        CHAIN_DROP
    } sli_chain_cmd_t;

    // Which per-cell flag the scan captures.
    typedef enum logic [1:0] {
        FLAG_GT_TAIL,
        FLAG_EQ,
        FLAG_TAIL
    } sli_flag_mode_t;

    typedef struct packed {
        sli_chain_cmd_t cmd;
        sli_flag_mode_t mode;
        logic [7:0]     cmp_key;
        sli_entry_t     load;
    } sli_chain_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMPARE,
        S_APPLY,
        S_DROP,
        S_RESPOND
    } sli_state_t;

endpackage

`default_nettype wire

[design/sli_cell.sv]
// One list cell: an entry register with its key comparators.
`default_nettype none

module sli_cell (
    input  wire                         aclk,
    input  wire sli_pkg::sli_cell_act_t act,
    input  wire sli_pkg::sli_entry_t    left_in,
    input  wire sli_pkg::sli_entry_t    right_in,
    input  wire sli_pkg::sli_entry_t    load_in,
    input  wire [7:0]                   cmp_key,
    output sli_pkg::sli_entry_t         entry_out,
    output logic                        gt,
    output logic                        eq
);

    sli_pkg::sli_entry_t entry_reg;
    sli_pkg::sli_entry_t entry_next;

    always_comb begin
        case (act)
            sli_pkg::CELL_LOAD:  entry_next = load_in;
            sli_pkg::CELL_LEFT:  entry_next = left_in;
            sli_pkg::CELL_RIGHT: entry_next = right_in;
            default:             entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;
    assign gt        = entry_reg.key > cmp_key;
    assign eq        = entry_reg.key == cmp_key;

endmodule

`default_nettype wire

[design/sli_scan.sv]
// Prefix OR over the captured cell flags, in log2 levels.
`default_nettype none

module sli_scan #(
    parameter int N = sli_pkg::SLI_CAPACITY
) (
    input  wire [N-1:0] flags,
    output logic [N-1:0] prefix
);

    localparam int LVL = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] stage [LVL+1];

    always_comb begin
        stage[0] = flags;
        for (int l = 0; l < LVL; l++) begin
            for (int i = 0; i < N; i++) begin
                if (i >= (1 << l)) begin
                    stage[l+1][i] = stage[l][i] | stage[l][i - (1 << l)];
                end else begin
                    stage[l+1][i] = stage[l][i];
                end
            end
        end
        prefix = stage[LVL];
    end

endmodule

`default_nettype wire

[design/sli_chain.sv]
// Row of list cells with flag capture and per-cell shift control.
`default_nettype none

module sli_chain #(
    parameter int CAPACITY = sli_pkg::SLI_CAPACITY,
    parameter int OCC_W    = $clog2(CAPACITY + 1)
) (
    input  wire                          aclk,
    input  wire sli_pkg::sli_chain_ctl_t ctl,
    input  wire [OCC_W-1:0]              occ,
    output logic                         found,
    output sli_pkg::sli_entry_t          head
);

    sli_pkg::sli_entry_t    ent [CAPACITY];
    sli_pkg::sli_cell_act_t act [CAPACITY];
    logic [CAPACITY-1:0]    gt_v;
    logic [CAPACITY-1:0]    eq_v;
    logic [CAPACITY-1:0]    flag_cur;
    logic [CAPACITY-1:0]    flag_reg;
    logic [CAPACITY-1:0]    flag_next;
    logic [CAPACITY-1:0]    pre;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic valid;
        logic tail;
        logic first;
        logic prior;

        assign valid = OCC_W'(i) < occ;
        assign tail  = OCC_W'(i) == occ;

        always_comb begin
            case (ctl.mode)
                sli_pkg::FLAG_GT_TAIL: flag_cur[i] = (gt_v[i] & valid) | tail;
                sli_pkg::FLAG_EQ:      flag_cur[i] = eq_v[i] & valid;
                default:               flag_cur[i] = tail;
            endcase
        end

        if (i == 0) begin : g_first
            assign prior = 1'b0;
        end else begin : g_rest
            assign prior = pre[i-1];
        end
        assign first = pre[i] & ~prior;

        // Insert and append: the first flagged cell loads, every cell after it
        // takes its left neighbor. Remove: the match and all cells after it take
        // their right neighbor. Drop: every cell takes its right neighbor.
        always_comb begin
            case (ctl.cmd)
                sli_pkg::CHAIN_PLACE: begin
                    if (first) begin
                        act[i] = sli_pkg::CELL_LOAD;
                    end else if (prior) begin
                        act[i] = sli_pkg::CELL_LEFT;
                    end else begin
                        act[i] = sli_pkg::CELL_HOLD;
                    end
                end
                sli_pkg::CHAIN_CLOSE: begin
                    act[i] = pre[i] ? sli_pkg::CELL_RIGHT : sli_pkg::CELL_HOLD;
                end
                sli_pkg::CHAIN_DROP: act[i] = sli_pkg::CELL_RIGHT;
                default:             act[i] = sli_pkg::CELL_HOLD;
            endcase
        end

        sli_cell u_cell (
            .aclk      (aclk),
            .act       (act[i]),
            .left_in   (ent[(i == 0) ? 0 : i - 1]),
            .right_in  (ent[(i == CAPACITY - 1) ? i : i + 1]),
            .load_in   (ctl.load),
            .cmp_key   (ctl.cmp_key),
            .entry_out (ent[i]),
            .gt        (gt_v[i]),
            .eq        (eq_v[i])
        );
    end

    assign flag_next = (ctl.cmd == sli_pkg::CHAIN_SCAN) ? flag_cur : flag_reg;

    always_ff @(posedge aclk) begin
        flag_reg <= flag_next;
    end

    sli_scan #(.N(CAPACITY)) u_scan (
        .flags  (flag_reg),
        .prefix (pre)
    );

    assign found = pre[CAPACITY-1];
    assign head  = ent[0];

endmodule

`default_nettype wire

[design/sorted_list_insert_remove_core.sv]
// Top level of the sorted list core: request sequencer, cell row, result register.
//
//   channel | ports                    | payload
//   request | s_valid, s_ready, s_data | sli_req_t: op, element_id, sort_key, drop_count
//   result  | m_valid, m_ready, m_data | sli_rsp_t: status, size, head entry
//
// Insert, append and remove take the request, capture the cell compare
// flags, shift the row and load the result. A drop of n entries moves
// the row one cell per cycle, n times in all, before the result loads.
// Rejected requests and a drop of zero skip the shift of the row.
// Reset (synchronous, active low) clears the size and the handshake state;
// cell contents stay undefined. A stalled result holds the sequencer in its
// last step; a new request is taken while an earlier result still waits.
`default_nettype none

module sorted_list_insert_remove_core #(
    parameter int CAPACITY = sli_pkg::SLI_CAPACITY
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire sli_pkg::sli_req_t s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output sli_pkg::sli_rsp_t      m_data
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (OCC_W > 9) ? OCC_W : 9;

    sli_pkg::sli_state_t     state_reg, state_next;
    sli_pkg::sli_req_t       req_reg, req_next;
    sli_pkg::sli_status_t    status_reg, status_next;
    logic [OCC_W-1:0]        occ_reg, occ_next;
    logic [8:0]              cnt_reg, cnt_next;
    logic                    m_valid_reg, m_valid_next;
    sli_pkg::sli_rsp_t       m_data_reg, m_data_next;
    sli_pkg::sli_chain_ctl_t ctl;
    sli_pkg::sli_entry_t     head;
    logic                    found;
    logic                    full;
    logic                    drop_big;
    logic [OCC_W+8:0]        size_ext;

    assign full     = occ_reg == OCC_W'(CAPACITY);
    assign drop_big = CMP_W'(req_reg.drop_count) > CMP_W'(occ_reg);
    assign size_ext = {9'd0, occ_reg};

    sli_chain #(.CAPACITY(CAPACITY), .OCC_W(OCC_W)) u_chain (
        .aclk  (aclk),
        .ctl   (ctl),
        .occ   (occ_reg),
        .found (found),
        .head  (head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sli_pkg::S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        status_reg <= status_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        status_next  = status_reg;
        occ_next     = occ_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;

        ctl.cmd          = sli_pkg::CHAIN_HOLD;
        ctl.cmp_key      = req_reg.sort_key;
        ctl.load.element = req_reg.element_id;
        ctl.load.key     = req_reg.sort_key;
        case (req_reg.op)
            sli_pkg::OP_INSERT: ctl.mode = sli_pkg::FLAG_GT_TAIL;
            sli_pkg::OP_REMOVE: ctl.mode = sli_pkg::FLAG_EQ;
            default:            ctl.mode = sli_pkg::FLAG_TAIL;
        endcase

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            sli_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = sli_pkg::S_COMPARE;
                end
            end
            sli_pkg::S_COMPARE: begin
                ctl.cmd     = sli_pkg::CHAIN_SCAN;
                status_next = sli_pkg::ST_DONE;
                case (req_reg.op)
                    sli_pkg::OP_INSERT, sli_pkg::OP_APPEND: begin
                        if (full) begin
                            status_next = sli_pkg::ST_FULL;
                            state_next  = sli_pkg::S_RESPOND;
                        end else begin
                            state_next = sli_pkg::S_APPLY;
                        end
                    end
                    sli_pkg::OP_REMOVE: state_next = sli_pkg::S_APPLY;
                    default: begin
                        cnt_next = req_reg.drop_count;
                        if (drop_big) begin
                            status_next = sli_pkg::ST_DROP_BIG;
                            state_next  = sli_pkg::S_RESPOND;
                        end else if (req_reg.drop_count == 9'd0) begin
                            state_next = sli_pkg::S_RESPOND;
                        end else begin
                            state_next = sli_pkg::S_DROP;
                        end
                    end
                endcase
            end
            sli_pkg::S_APPLY: begin
                state_next = sli_pkg::S_RESPOND;
                if (req_reg.op == sli_pkg::OP_REMOVE) begin
                    if (found) begin
                        ctl.cmd  = sli_pkg::CHAIN_CLOSE;
                        occ_next = occ_reg - 1'b1;
                    end else begin
                        status_next = sli_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    ctl.cmd  = sli_pkg::CHAIN_PLACE;
                    occ_next = occ_reg + 1'b1;
                end
            end
            sli_pkg::S_DROP: begin
                ctl.cmd  = sli_pkg::CHAIN_DROP;
                occ_next = occ_reg - 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 9'd1) begin
                    state_next = sli_pkg::S_RESPOND;
                end
            end
            sli_pkg::S_RESPOND: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = status_reg;
                    m_data_next.list_size   = size_ext[8:0];
                    m_data_next.head_valid  = occ_reg != '0;
                    m_data_next.head_element = (occ_reg != '0) ? head.element : 8'd0;
                    m_data_next.head_key    = (occ_reg != '0) ? head.key : 8'd0;
                    state_next              = sli_pkg::S_IDLE;
                end
            end
            default: state_next = sli_pkg::S_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`include "sorted_list_insert_remove_core_assert.svh"

    // The size never passes the number of cells.
    `SLI_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= OCC_W'(CAPACITY))
    // A taken request closes the request side until its result is loaded.
    `SLI_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)
    // While waiting for a request the list does not change size.
    `SLI_ASSERT_NEXT(a_idle_stable, state_reg == sli_pkg::S_IDLE, occ_reg == $past(occ_reg))
    // A result slot that is free at the last step is filled.
    `SLI_ASSERT_NEXT(a_respond_loads,
        state_reg == sli_pkg::S_RESPOND && (!m_valid_reg || m_ready),
        m_valid && state_reg == sli_pkg::S_IDLE)

endmodule

`default_nettype wire

[verif/sorted_list_insert_remove_core_test.sv]
// Testbench for the sorted list core: directed and random list requests against a shadow list.
`timescale 1ns / 100ps

module sorted_list_insert_remove_core_test;
    import sli_pkg::*;

    localparam int LIST_CAPACITY  = SLI_CAPACITY;
    localparam int SETTLE_CYCLES  = LIST_CAPACITY + 40;
    localparam int WATCHDOG_LIMIT = 4000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sli_req_t s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sli_rsp_t m_data;

    sli_entry_t  shadow_list[$];
    sli_rsp_t    awaited_responses[$];
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned requests_sent  = 0;
    int unsigned results_seen   = 0;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;

    sorted_list_insert_remove_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Applies one request to the shadow list and returns the response it must produce.
    function automatic sli_rsp_t apply_list_op(input sli_req_t req);
        sli_rsp_t   rsp;
        sli_entry_t item;
        int         pos;
        int         depth;
        rsp = '0;
        item.element = req.element_id;
        item.key = req.sort_key;
        depth = shadow_list.size();
        rsp.status = ST_DONE;
        case (req.op)
            OP_INSERT: begin
                if (depth >= LIST_CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < depth && shadow_list[pos].key <= req.sort_key) pos++;
                    shadow_list.insert(pos, item);
                end
            end
            OP_REMOVE: begin
                rsp.status = ST_NOT_FOUND;
                for (pos = 0; pos < depth; pos++) begin
                    if (shadow_list[pos].key == req.sort_key) begin
                        shadow_list.delete(pos);
                        rsp.status = ST_DONE;
                        break;
                    end
                end
            end
            OP_APPEND: begin
                if (depth >= LIST_CAPACITY) rsp.status = ST_FULL;
                else shadow_list.push_back(item);
            end
            default: begin
                if (req.drop_count > depth) begin
                    rsp.status = ST_DROP_BIG;
                end else begin
                    repeat (req.drop_count) void'(shadow_list.pop_front());
                end
            end
        endcase
        depth = shadow_list.size();
        rsp.list_size = depth[8:0];
        if (depth > 0) begin
            rsp.head_valid = 1'b1;
            rsp.head_element = shadow_list[0].element;
            rsp.head_key = shadow_list[0].key;
        end
        return rsp;
    endfunction

    function automatic sli_req_t build_request(input sli_op_t op, input logic [7:0] element_id,
                                               input logic [7:0] sort_key,
                                               input logic [8:0] drop_count);
        sli_req_t req;
        req.op = op;
        req.element_id = element_id;
        req.sort_key = sort_key;
        req.drop_count = drop_count;
        return req;
    endfunction

    // Valid stays high between back-to-back requests; it drops during a sender gap and while waiting for responses.
    task automatic send_request(input sli_req_t req);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        awaited_responses.push_back(apply_list_op(req));
        requests_sent++;
    endtask

    task automatic wait_for_responses;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_responses.size() != 0) @(posedge aclk);
    endtask

    task automatic send_key_op(input sli_op_t op, input logic [7:0] element_id,
                               input logic [7:0] sort_key);
        send_request(build_request(op, element_id, sort_key, 9'($urandom)));
    endtask

    task automatic send_drop(input int count);
        send_request(build_request(OP_DROP, 8'($urandom), 8'($urandom), count[8:0]));
    endtask

    task automatic test_directed_cases;
        // Empty list: nothing to remove, nothing to drop.
        send_key_op(OP_REMOVE, 8'h00, 8'h00);
        send_drop(0);
        send_drop(1);
        send_drop(256);
        send_key_op(OP_INSERT, 8'hFF, 8'hFF);
        send_key_op(OP_INSERT, 8'h00, 8'h00);
        // An equal key lands behind the existing one.
        send_key_op(OP_INSERT, 8'h01, 8'h00);
        // Append breaks the order; the next insert stops at the first larger key.
        send_key_op(OP_APPEND, 8'hAA, 8'h0A);
        send_key_op(OP_INSERT, 8'h55, 8'h05);
        send_key_op(OP_REMOVE, 8'h00, 8'h00);
        send_key_op(OP_REMOVE, 8'h00, 8'h0A);
        send_key_op(OP_REMOVE, 8'hFF, 8'hC8);
        send_drop(4);
        send_drop(0);
        send_drop(1);
        send_key_op(OP_APPEND, 8'h80, 8'h80);
        send_drop(3);
        send_drop(3);
        wait_for_responses();
    endtask

    task automatic test_full_list;
        send_drop(shadow_list.size());
        while (shadow_list.size() < LIST_CAPACITY) begin
            if ($urandom_range(99) < 75) send_key_op(OP_INSERT, 8'($urandom), 8'($urandom));
            else send_key_op(OP_APPEND, 8'($urandom), 8'($urandom));
        end
        send_key_op(OP_INSERT, 8'($urandom), 8'($urandom));
        send_key_op(OP_APPEND, 8'($urandom), 8'($urandom));
        send_key_op(OP_REMOVE, 8'($urandom),
                    shadow_list[$urandom_range(LIST_CAPACITY - 1)].key);
        send_drop(256);
        send_key_op(OP_APPEND, 8'($urandom), 8'($urandom));
        send_drop(256);
        wait_for_responses();
    endtask

    // Mostly meaningful requests (removes of present keys, small drops) with some noise.
    task automatic test_random_mix(input int count);
        int         pick;
        int         depth;
        logic [7:0] key;
        repeat (count) begin
            pick = $urandom_range(99);
            depth = shadow_list.size();
            key = ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
            if (pick < 40) begin
                send_key_op(OP_INSERT, 8'($urandom), key);
            end else if (pick < 60 && depth > 0) begin
                send_key_op(OP_REMOVE, 8'($urandom), shadow_list[$urandom_range(depth - 1)].key);
            end else if (pick < 65) begin
                send_key_op(OP_REMOVE, 8'($urandom), key);
            end else if (pick < 80) begin
                send_key_op(OP_APPEND, 8'($urandom), key);
            end else if (pick < 95) begin
                send_drop($urandom_range((depth < 4) ? depth : 4));
            end else begin
                send_request(build_request(OP_DROP, 8'($urandom), 8'($urandom),
                                           9'($urandom)));
            end
        end
        wait_for_responses();
    endtask

    always @(posedge aclk) begin : result_check
        sli_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (awaited_responses.size() == 0) begin
                $error("unexpected response: %p", m_data);
                error_count++;
            end else begin
                want = awaited_responses.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    error_count++;
                end
                if (m_data.list_size !== want.list_size) begin
                    $error("list_size: expected %0d, got %0d", want.list_size,
                           m_data.list_size);
                    error_count++;
                end
                if (m_data.head_valid !== want.head_valid) begin
                    $error("head_valid: expected %0d, got %0d", want.head_valid,
                           m_data.head_valid);
                    error_count++;
                end
                if (m_data.head_element !== want.head_element) begin
                    $error("head_element: expected %0d, got %0d", want.head_element,
                           m_data.head_element);
                    error_count++;
                end
                if (m_data.head_key !== want.head_key) begin
                    $error("head_key: expected %0d, got %0d", want.head_key, m_data.head_key);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Ends the run when neither channel has moved a request or result for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_gap_pct = 20;
        recv_stall_pct = 47;
        test_directed_cases();
        test_random_mix(60);

        send_gap_pct = 47;
        recv_stall_pct = 20;
        test_full_list();

        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random_mix(80);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d list requests under three pacing phases and checked %0d results.",
                 requests_sent, results_seen);
        $display("%s %s", "Exercised sorted insert, remove, append, front drop,",
                 "a full list and drops past the size.");
        if (error_count == 0 && awaited_responses.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sorted_list_insert_remove_core.f]
+incdir+design
design/sli_pkg.sv
design/sli_cell.sv
design/sli_scan.sv
design/sli_chain.sv
design/sorted_list_insert_remove_core.sv
verif/sorted_list_insert_remove_core_test.sv
